@@ hw/rtl/pwr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_pkg
// Shared types and constants of the pid controller with setpoint ramp and
// feedback averaging filter.
// ----------------------------------------------------------------------------
package pwr_pkg;

  // fixed field widths
  localparam int GAIN_BITS   = 16;
  localparam int LIMIT_BITS  = 16;
  localparam int RISE_BITS   = 15;
  localparam int FALL_BITS   = 16;
  localparam int OPCODE_BITS = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // averaging window
  localparam int FILTER_TAPS = 4;
  localparam int TAP_SHIFT   = 2;

  // queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = 1;
  localparam int QCNT_BITS = 2;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_SAMPLE = 2'd0,
    OP_PRESET = 2'd1,
    OP_RUN    = 2'd2,
    OP_HOLD   = 2'd3
  } pwr_op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DERIV_MODE = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_LIMIT_HIGH = 3'd4,
    REG_LIMIT_LOW  = 3'd5,
    REG_RISE_RATE  = 3'd6,
    REG_FALL_RATE  = 3'd7
  } pwr_reg_e;

  // reset values of the configuration registers
  localparam logic                  RST_DERIV_MODE = 1'b1;
  localparam logic [LIMIT_BITS-1:0] RST_LIMIT_HIGH = 16'h7fff;
  localparam logic [LIMIT_BITS-1:0] RST_LIMIT_LOW  = 16'h8000;
  localparam logic [RISE_BITS-1:0]  RST_RISE_RATE  = 15'h7fff;
  localparam logic [FALL_BITS-1:0]  RST_FALL_RATE  = 16'h8000;

  typedef struct packed {
    logic                   deriv_mode;
    logic [GAIN_BITS-1:0]   gain_p;
    logic [GAIN_BITS-1:0]   gain_i;
    logic [GAIN_BITS-1:0]   gain_d;
    logic [LIMIT_BITS-1:0]  limit_high;
    logic [LIMIT_BITS-1:0]  limit_low;
    logic [RISE_BITS-1:0]   rise_rate;
    logic [FALL_BITS-1:0]   fall_rate;
  } pwr_cfg_t;

  // decoded item class, all clear for a hold item
  typedef struct packed {
    logic smp;
    logic pre;
    logic run;
  } pwr_kind_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } pwr_back_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/pwr_item_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_item_if
// Input item channel: opcode, feedback sample and setpoint.
// ----------------------------------------------------------------------------
interface pwr_item_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic signed [SAMPLE_BITS-1:0] feedback;
  logic signed [SAMPLE_BITS-1:0] setpoint;

  modport source (output valid, output opcode, output feedback, output setpoint,
                  input ready);
  modport sink   (input valid, input opcode, input feedback, input setpoint,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pwr_result_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_result_if
// Result channel: drive, error and filtered feedback.
// ----------------------------------------------------------------------------
interface pwr_result_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] drive;
  logic signed [SAMPLE_BITS:0]   error;
  logic signed [SAMPLE_BITS-1:0] filtered_feedback;

  modport source (output valid, output drive, output error, output filtered_feedback,
                  input ready);
  modport sink   (input valid, input drive, input error, input filtered_feedback,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pwr_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pwr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pwr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_front
// Accepts input items, classifies them by opcode, keeps the one operand each
// class needs and queues them for the back end.
// ----------------------------------------------------------------------------
module pwr_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  pwr_item_if.sink                             item,
  output logic                                 q_valid,
  output pwr_pkg::pwr_kind_t                   q_kind,
  output logic signed [SAMPLE_BITS-1:0]        q_value,
  input  logic                                 q_pop,
  output logic [pwr_pkg::QCNT_BITS-1:0]        q_count
);
  import pwr_pkg::*;

  pwr_kind_t                     kind_mem  [QDEPTH];
  logic signed [SAMPLE_BITS-1:0] value_mem [QDEPTH];
  logic [QPTR_BITS-1:0]          wr_ptr;
  logic [QPTR_BITS-1:0]          rd_ptr;
  logic [QCNT_BITS-1:0]          count;
  logic                          push;
  pwr_kind_t                     kind_in;
  logic signed [SAMPLE_BITS-1:0] value_in;

  // classify
  always_comb begin
    kind_in  = '0;
    value_in = item.feedback;
    unique case (pwr_op_e'(item.opcode))
      OP_SAMPLE: kind_in.smp = 1'b1;
      OP_PRESET: kind_in.pre = 1'b1;
      OP_RUN: begin
        kind_in.run = 1'b1;
        value_in    = item.setpoint;
      end
      OP_HOLD: kind_in = '0;
    endcase
  end

  assign item.ready = (count != QCNT_BITS'(QDEPTH));
  assign push       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      priority if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
      else count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem[wr_ptr]  <= kind_in;
      value_mem[wr_ptr] <= value_in;
    end
  end

  assign q_valid = (count != '0);
  assign q_kind  = kind_mem[rd_ptr];
  assign q_value = value_mem[rd_ptr];
  assign q_count = count;

endmodule
`default_nettype wire

@@ hw/rtl/pwr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_back
// Executes queued items: filter and ramp update, gain multiplies, then sum,
// clamp and integrator update into the result register.
// ----------------------------------------------------------------------------
module pwr_back #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pwr_pkg::pwr_cfg_t             cfg,
  input  logic                          q_valid,
  input  pwr_pkg::pwr_kind_t            q_kind,
  input  logic signed [SAMPLE_BITS-1:0] q_value,
  output logic                          q_pop,
  pwr_result_if.source                  result,
  output pwr_pkg::pwr_back_stat_t       stat
);
  import pwr_pkg::*;

  localparam int S    = SAMPLE_BITS;
  localparam int ERRW = S + 1;
  localparam int SUMW = S + TAP_SHIFT;
  localparam int CMPW = (S + 2 > RISE_BITS + 2) ? S + 2 : RISE_BITS + 2;
  localparam int PW   = GAIN_BITS + ERRW;
  localparam int CLW  = PW + GAIN_FRAC_BITS + 2;
  localparam logic signed [CLW-1:0] FBIAS = CLW'((1 << GAIN_FRAC_BITS) - 1);

  // controller state
  logic signed [S-1:0]          taps [FILTER_TAPS];
  logic signed [SUMW-1:0]       tap_sum;
  logic signed [S-1:0]          fv;
  logic signed [ERRW-1:0]       fdelta;
  logic signed [ERRW-1:0]       rt;
  logic signed [ERRW-1:0]       err_q;
  logic signed [LIMIT_BITS-1:0] integ;
  logic signed [LIMIT_BITS-1:0] drive;

  // stage a
  logic                   a_valid;
  logic                   a_run;
  logic signed [ERRW-1:0] a_err;
  logic signed [S-1:0]    a_fv;
  logic signed [ERRW-1:0] a_deriv;

  // stage b
  logic                   b_valid;
  logic                   b_run;
  logic signed [ERRW-1:0] b_err;
  logic signed [S-1:0]    b_fv;
  logic signed [PW-1:0]   b_prod_p;
  logic signed [PW-1:0]   b_prod_i;
  logic signed [PW-1:0]   b_prod_d;

  // result register
  logic                   res_valid;
  logic signed [ERRW-1:0] res_err;
  logic signed [S-1:0]    res_fv;

  logic adv;
  logic pop;

  // stage a combinational
  logic signed [SUMW-1:0]       sum_shift;
  logic signed [SUMW-1:0]       sum_bias;
  logic signed [S-1:0]          fv_avg;
  logic signed [ERRW-1:0]       delta_new;
  logic signed [CMPW-1:0]       diff;
  logic signed [CMPW-1:0]       rise_x;
  logic signed [CMPW-1:0]       fall_x;
  logic signed [CMPW-1:0]       rt_step;
  logic signed [ERRW-1:0]       rt_new;
  logic signed [ERRW-1:0]       err_new;
  logic signed [ERRW-1:0]       deriv;

  // stage c combinational
  logic signed [CLW-1:0]        p_x;
  logic signed [CLW-1:0]        d_x;
  logic signed [CLW-1:0]        u_sum;
  logic signed [CLW-1:0]        acc;
  logic signed [CLW-1:0]        acc_t;
  logic signed [CLW-1:0]        lim_hi;
  logic signed [CLW-1:0]        lim_lo;
  logic signed [LIMIT_BITS-1:0] drive_new;
  logic signed [LIMIT_BITS-1:0] integ_new;

  function automatic logic signed [CLW-1:0] trunc_frac(input logic signed [CLW-1:0] v);
    logic signed [CLW-1:0] bias;
    bias = v[CLW-1] ? FBIAS : '0;
    return (v + bias) >>> GAIN_FRAC_BITS;
  endfunction

  function automatic logic signed [LIMIT_BITS-1:0] clamp_lim(
    input logic signed [CLW-1:0] v,
    input logic signed [CLW-1:0] hi,
    input logic signed [CLW-1:0] lo
  );
    logic signed [CLW-1:0] r;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return LIMIT_BITS'(r);
  endfunction

  assign adv   = !res_valid || result.ready;
  assign pop   = adv && q_valid;
  assign q_pop = pop;

  // filter and ramp
  always_comb begin
    sum_shift = tap_sum - SUMW'(taps[FILTER_TAPS-1]) + SUMW'(q_value);
    sum_bias  = sum_shift[SUMW-1] ? SUMW'(FILTER_TAPS - 1) : '0;
    fv_avg    = S'((sum_shift + sum_bias) >>> TAP_SHIFT);
    delta_new = ERRW'(fv_avg) - ERRW'(fv);

    diff   = CMPW'(q_value) - CMPW'(rt);
    rise_x = CMPW'($signed({1'b0, cfg.rise_rate}));
    fall_x = cfg.fall_rate[FALL_BITS-1] ? CMPW'($signed(cfg.fall_rate)) : '0;
    if (diff > rise_x) rt_step = CMPW'(rt) + rise_x;
    else if (diff < fall_x) rt_step = CMPW'(rt) + fall_x;
    else rt_step = CMPW'(q_value);
    rt_new  = ERRW'(rt_step);
    err_new = rt_new - ERRW'(fv);

    deriv = cfg.deriv_mode ? fdelta : (ERRW'(taps[0]) - ERRW'(taps[1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILTER_TAPS; i++) taps[i] <= '0;
      tap_sum <= '0;
      fv      <= '0;
      fdelta  <= '0;
      rt      <= '0;
      err_q   <= '0;
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pop;
      if (pop) begin
        if (q_kind.smp) begin
          for (int i = FILTER_TAPS - 1; i > 0; i--) taps[i] <= taps[i-1];
          taps[0] <= q_value;
          tap_sum <= sum_shift;
          fv      <= fv_avg;
          fdelta  <= delta_new;
        end else if (q_kind.pre) begin
          for (int i = 0; i < FILTER_TAPS; i++) taps[i] <= q_value;
          tap_sum <= SUMW'(q_value) <<< TAP_SHIFT;
          fv      <= q_value;
        end else if (q_kind.run) begin
          rt    <= rt_new;
          err_q <= err_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_run   <= q_kind.run;
      a_err   <= q_kind.run ? err_new : err_q;
      a_deriv <= deriv;
      if (q_kind.smp) a_fv <= fv_avg;
      else if (q_kind.pre) a_fv <= q_value;
      else a_fv <= fv;
    end
  end

  // gain multiplies
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      b_run    <= a_run;
      b_err    <= a_err;
      b_fv     <= a_fv;
      b_prod_p <= PW'($signed(cfg.gain_p)) * PW'(a_err);
      b_prod_i <= PW'($signed(cfg.gain_i)) * PW'(a_err);
      b_prod_d <= PW'($signed(cfg.gain_d)) * PW'(a_deriv);
    end
  end

  // sum, clamp and integrator
  always_comb begin
    lim_hi    = CLW'($signed(cfg.limit_high));
    lim_lo    = CLW'($signed(cfg.limit_low));
    p_x       = trunc_frac(CLW'(b_prod_p));
    d_x       = trunc_frac(CLW'(b_prod_d));
    u_sum     = p_x + CLW'(integ) + d_x;
    acc       = (CLW'(integ) <<< GAIN_FRAC_BITS) + CLW'(b_prod_i);
    acc_t     = trunc_frac(acc);
    drive_new = clamp_lim(u_sum, lim_hi, lim_lo);
    integ_new = clamp_lim(acc_t, lim_hi, lim_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive     <= '0;
      integ     <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= b_valid;
      if (b_valid && b_run) begin
        drive <= drive_new;
        integ <= integ_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid) begin
      res_err <= b_err;
      res_fv  <= b_fv;
    end
  end

  assign result.valid             = res_valid;
  assign result.drive             = SAMPLE_BITS'(drive);
  assign result.error             = res_err;
  assign result.filtered_feedback = res_fv;

  assign stat.a_valid = a_valid;
  assign stat.b_valid = b_valid;

endmodule
`default_nettype wire

@@ hw/rtl/pid_with_ramp_and_average_filter_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pid_with_ramp_and_average_filter_core
// PID controller with a ramped setpoint and a four-tap feedback average.
// ----------------------------------------------------------------------------
// item channel: one beat per opcode; sample shifts feedback into the window,
//   preset fills the window, run steps the ramp and the control law, and the
//   fourth opcode only reports the held values
// result channel: one beat per item, in item order, carrying drive, error
//   and filtered feedback as they stand after that item
// cfg channel: register writes, always ready, meant for when the block is idle
// throughput: one item per cycle unless stalled; a two-entry queue links
//   the front and the three-stage back end (filter/ramp, multiply, sum/clamp)
// result path: an accepted item moves through a queue slot, the filter/ramp
//   stage and the multiply stage into the result register
// stall: a held result freezes the back end; the queue takes up to two more
//   beats, then item ready drops
// reset: state and queue cleared, registers to their defaults
//   (filtered derivative, zero gains, full-range limits and ramp rates)
// ----------------------------------------------------------------------------
module pid_with_ramp_and_average_filter_core #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  pwr_item_if.sink     item,
  pwr_result_if.source result,
  pwr_cfg_if.sink      cfg
);
  import pwr_pkg::*;

  pwr_cfg_t                      cfg_q;
  logic                          q_valid;
  pwr_kind_t                     q_kind;
  logic signed [SAMPLE_BITS-1:0] q_value;
  logic                          q_pop;
  logic [QCNT_BITS-1:0]          q_count;
  pwr_back_stat_t                back_stat;

  // configuration registers, writes never stall
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.deriv_mode <= RST_DERIV_MODE;
      cfg_q.gain_p     <= '0;
      cfg_q.gain_i     <= '0;
      cfg_q.gain_d     <= '0;
      cfg_q.limit_high <= RST_LIMIT_HIGH;
      cfg_q.limit_low  <= RST_LIMIT_LOW;
      cfg_q.rise_rate  <= RST_RISE_RATE;
      cfg_q.fall_rate  <= RST_FALL_RATE;
    end else if (cfg.valid) begin
      unique case (pwr_reg_e'(cfg.index))
        REG_DERIV_MODE: cfg_q.deriv_mode <= cfg.data[0];
        REG_GAIN_P:     cfg_q.gain_p     <= cfg.data;
        REG_GAIN_I:     cfg_q.gain_i     <= cfg.data;
        REG_GAIN_D:     cfg_q.gain_d     <= cfg.data;
        REG_LIMIT_HIGH: cfg_q.limit_high <= cfg.data;
        REG_LIMIT_LOW:  cfg_q.limit_low  <= cfg.data;
        REG_RISE_RATE:  cfg_q.rise_rate  <= cfg.data[RISE_BITS-1:0];
        REG_FALL_RATE:  cfg_q.fall_rate  <= cfg.data;
      endcase
    end
  end

  // front: accept, classify and queue
  pwr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_kind  (q_kind),
    .q_value (q_value),
    .q_pop   (q_pop),
    .q_count (q_count)
  );

  // back: filter, ramp, gains, clamp, result register
  pwr_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_q),
    .q_valid (q_valid),
    .q_kind  (q_kind),
    .q_value (q_value),
    .q_pop   (q_pop),
    .result  (result),
    .stat    (back_stat)
  );

`ifndef SYNTHESIS
  // an accepted beat is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (q_count != '0))
    else $error("accepted item missing from queue");

  // a held result must freeze the back end
  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !q_pop)
    else $error("queue popped while result stalled");

  // a new result comes only from an occupied multiply stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(back_stat.b_valid))
    else $error("result appeared without a multiply stage beat");
`endif

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pid core with setpoint ramp and four-tap
// feedback average. Every accepted item beat runs through an in-bench copy of
// the controller, and each result beat is matched field by field against the
// oldest outstanding prediction. The run covers directed corner cases,
// back-pressure and random control sequences under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import pwr_pkg::*;

  localparam int     SAMPLE_BITS = 16;
  localparam int     FRAC_BITS   = 8;
  localparam longint FRAC_SCALE  = longint'(1) << FRAC_BITS;
  localparam int     CYCLE_LIMIT = 200000;
  // margin waited after every predicted result beat has come back
  localparam int     DRAIN_SLACK = 5;
  localparam int     REPORT_CAP  = 40;
  localparam int     IDLE_PCT    = 32;

  // one predicted result beat
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] drive;
    logic signed [SAMPLE_BITS:0]   error;
    logic signed [SAMPLE_BITS-1:0] filtered;
  } ctrl_out_t;

  logic clk;
  logic rst;

  pwr_item_if   #(.SAMPLE_BITS(SAMPLE_BITS)) item_bus ();
  pwr_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_bus ();
  pwr_cfg_if                                 cfg_bus ();

  pid_with_ramp_and_average_filter_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // --------------------------------------------------------------------------
  // controller copy: register shadow and datapath state
  // --------------------------------------------------------------------------
  pwr_cfg_t                      cfg_shadow;
  logic signed [SAMPLE_BITS-1:0] tap_q [FILTER_TAPS];
  logic signed [SAMPLE_BITS-1:0] filt_now;
  logic signed [SAMPLE_BITS-1:0] filt_prev;
  logic signed [SAMPLE_BITS:0]   filt_delta;
  logic signed [SAMPLE_BITS:0]   ramp_q;
  logic signed [SAMPLE_BITS-1:0] integ_q;
  logic signed [SAMPLE_BITS-1:0] drive_q;
  logic signed [SAMPLE_BITS:0]   err_q;

  ctrl_out_t outputs_due [$];

  int  mismatch_count;
  int  beats_checked;
  int  cycle_count;
  bit  src_idle_en;
  bit  sink_idle_en;
  int  ready_hold_req;
  int  ready_hold_left;
  int  plant_level;

  // clamp used for both drive and integrator; with crossed limits the upper
  // bound is tested first
  function automatic longint clamp_to_limits(longint v);
    longint hi;
    longint lo;
    hi = longint'($signed(cfg_shadow.limit_high));
    lo = longint'($signed(cfg_shadow.limit_low));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // applies one item to the controller copy and returns the result beat
  function automatic ctrl_out_t advance_controller(pwr_op_e op,
                                                   logic signed [15:0] fb,
                                                   logic signed [15:0] sp);
    longint    sum;
    longint    rise;
    longint    fall;
    longint    ramp;
    longint    diff;
    longint    err;
    longint    deriv;
    longint    p_term;
    longint    d_term;
    longint    acc;
    ctrl_out_t res;
    case (op)
      OP_SAMPLE: begin
        for (int i = FILTER_TAPS - 1; i > 0; i--) tap_q[i] = tap_q[i-1];
        tap_q[0] = fb;
        sum = 0;
        for (int i = 0; i < FILTER_TAPS; i++) sum += longint'(tap_q[i]);
        filt_prev  = filt_now;
        // signed division truncates toward zero
        filt_now   = SAMPLE_BITS'(sum / FILTER_TAPS);
        filt_delta = (SAMPLE_BITS+1)'(longint'(filt_now) - longint'(filt_prev));
      end
      OP_PRESET: begin
        // window and average only; previous value and delta stay put
        for (int i = 0; i < FILTER_TAPS; i++) tap_q[i] = fb;
        filt_now = fb;
      end
      OP_RUN: begin
        rise = longint'(cfg_shadow.rise_rate);
        fall = longint'($signed(cfg_shadow.fall_rate));
        // a positive fall rate freezes downward ramping
        if (fall > 0) fall = 0;
        ramp = longint'(ramp_q);
        diff = longint'(sp) - ramp;
        if (diff > rise) ramp = ramp + rise;
        else if (diff < fall) ramp = ramp + fall;
        else ramp = longint'(sp);
        ramp_q = (SAMPLE_BITS+1)'(ramp);
        err    = ramp - longint'(filt_now);
        err_q  = (SAMPLE_BITS+1)'(err);
        deriv  = cfg_shadow.deriv_mode ? longint'(filt_delta)
                                       : longint'(tap_q[0]) - longint'(tap_q[1]);
        p_term = (longint'($signed(cfg_shadow.gain_p)) * err) / FRAC_SCALE;
        d_term = (longint'($signed(cfg_shadow.gain_d)) * deriv) / FRAC_SCALE;
        drive_q = SAMPLE_BITS'(clamp_to_limits(p_term + longint'(integ_q) + d_term));
        acc = longint'(integ_q) * FRAC_SCALE
            + longint'($signed(cfg_shadow.gain_i)) * err;
        integ_q = SAMPLE_BITS'(clamp_to_limits(acc / FRAC_SCALE));
      end
      default: ;  // hold item reports the held values
    endcase
    res.drive    = drive_q;
    res.error    = err_q;
    res.filtered = filt_now;
    return res;
  endfunction

  function automatic void reset_controller();
    cfg_shadow.deriv_mode = RST_DERIV_MODE;
    cfg_shadow.gain_p     = '0;
    cfg_shadow.gain_i     = '0;
    cfg_shadow.gain_d     = '0;
    cfg_shadow.limit_high = RST_LIMIT_HIGH;
    cfg_shadow.limit_low  = RST_LIMIT_LOW;
    cfg_shadow.rise_rate  = RST_RISE_RATE;
    cfg_shadow.fall_rate  = RST_FALL_RATE;
    for (int i = 0; i < FILTER_TAPS; i++) tap_q[i] = '0;
    filt_now   = '0;
    filt_prev  = '0;
    filt_delta = '0;
    ramp_q     = '0;
    integ_q    = '0;
    drive_q    = '0;
    err_q      = '0;
  endfunction

  // --------------------------------------------------------------------------
  // clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, outputs_due.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // result side: check each accepted beat, then pick the next ready
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("mismatch at result beat %0d: %s", beats_checked, msg);
  endtask

  task automatic check_result_beat();
    ctrl_out_t want;
    if (outputs_due.size() == 0) begin
      flag_mismatch($sformatf("beat with nothing outstanding (drive %0d)",
                              result_bus.drive));
      return;
    end
    want = outputs_due.pop_front();
    if (result_bus.drive !== want.drive)
      flag_mismatch($sformatf("drive got %0d want %0d", result_bus.drive, want.drive));
    if (result_bus.error !== want.error)
      flag_mismatch($sformatf("error got %0d want %0d", result_bus.error, want.error));
    if (result_bus.filtered_feedback !== want.filtered)
      flag_mismatch($sformatf("filtered_feedback got %0d want %0d",
                              result_bus.filtered_feedback, want.filtered));
    beats_checked++;
  endtask

  // values read here are the ones from before the edge, so the handshake
  // is judged exactly as the core sees it
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) check_result_beat();
    if (ready_hold_req > 0) begin
      ready_hold_left = ready_hold_req;
      ready_hold_req  = 0;
    end
    if (ready_hold_left > 0) begin
      // long hold-off: the back end freezes and the queue fills
      ready_hold_left--;
      result_bus.ready <= 1'b0;
    end else if (sink_idle_en) begin
      result_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // item and register side
  // --------------------------------------------------------------------------
  // sends one item beat; valid is left high so back-to-back beats need no
  // second assignment within a step
  task automatic send_item(pwr_op_e op, logic [15:0] fb, logic [15:0] sp);
    if (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      item_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    item_bus.valid    <= 1'b1;
    item_bus.opcode   <= op;
    item_bus.feedback <= fb;
    item_bus.setpoint <= sp;
    do @(posedge clk); while (!item_bus.ready);
    outputs_due.push_back(advance_controller(op, fb, sp));
  endtask

  // stops offering items and waits until every predicted beat has come back
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(pwr_reg_e idx, logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_DERIV_MODE: cfg_shadow.deriv_mode = val[0];
      REG_GAIN_P:     cfg_shadow.gain_p     = val;
      REG_GAIN_I:     cfg_shadow.gain_i     = val;
      REG_GAIN_D:     cfg_shadow.gain_d     = val;
      REG_LIMIT_HIGH: cfg_shadow.limit_high = val;
      REG_LIMIT_LOW:  cfg_shadow.limit_low  = val;
      REG_RISE_RATE:  cfg_shadow.rise_rate  = val[RISE_BITS-1:0];
      REG_FALL_RATE:  cfg_shadow.fall_rate  = val;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_config(logic mode, logic [15:0] gp, logic [15:0] gi,
                                logic [15:0] gd, logic [15:0] hi,
                                logic [15:0] lo, logic [15:0] rise,
                                logic [15:0] fall);
    write_reg(REG_DERIV_MODE, {15'd0, mode});
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_LIMIT_HIGH, hi);
    write_reg(REG_LIMIT_LOW, lo);
    write_reg(REG_RISE_RATE, rise);
    write_reg(REG_FALL_RATE, fall);
  endtask

  // --------------------------------------------------------------------------
  // value pickers for the random part
  // --------------------------------------------------------------------------
  // mostly near a slowly wandering plant level, now and then the extremes
  // or anything at all
  function automatic logic [15:0] pick_level(int spread);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1, 2:    return 16'($urandom);
      default: return 16'(plant_level + int'($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  // random register setting; limits and rates include their extremes,
  // crossed limits and a positive fall rate
  task automatic program_random_config();
    logic [15:0] hi;
    logic [15:0] lo;
    logic [15:0] rise;
    logic [15:0] fall;
    case ($urandom_range(0, 5))
      0: begin
        hi = 16'h7fff;
        lo = 16'h8000;
      end
      1: begin
        hi = 16'(-int'($urandom_range(0, 2000)));
        lo = 16'($urandom_range(0, 2000));
      end
      2: begin
        hi = 16'(int'($urandom_range(0, 4000)) - 2000);
        lo = hi;
      end
      default: begin
        hi = 16'($urandom_range(100, 20000));
        lo = 16'(-int'($urandom_range(100, 20000)));
      end
    endcase
    case ($urandom_range(0, 5))
      0:       rise = 16'h0000;
      1:       rise = 16'h7fff;
      default: rise = 16'($urandom_range(1, 3000));
    endcase
    case ($urandom_range(0, 6))
      0:       fall = 16'h8000;
      1:       fall = 16'h0000;
      2:       fall = 16'($urandom_range(1, 500));
      default: fall = 16'(-int'($urandom_range(1, 3000)));
    endcase
    program_config(1'($urandom), pick_gain(), pick_gain(), pick_gain(),
                   hi, lo, rise, fall);
  endtask

  // a control cycle: optional preset or stray hold, a few samples, one run
  task automatic send_control_cycle(inout int sent);
    int n_samples;
    n_samples   = $urandom_range(0, 4);
    plant_level = plant_level + int'($urandom_range(0, 2000)) - 1000;
    if (plant_level > 20000) plant_level = 20000;
    if (plant_level < -20000) plant_level = -20000;
    case ($urandom_range(0, 19))
      0: send_item(OP_HOLD, 16'($urandom), 16'($urandom));
      1, 2: begin
        send_item(OP_PRESET, pick_level(300), 16'($urandom));
        sent++;
      end
      default: ;
    endcase
    repeat (n_samples) begin
      send_item(OP_SAMPLE, pick_level(300), 16'($urandom));
      sent++;
    end
    send_item(OP_RUN, 16'($urandom), pick_level(3000));
    sent++;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // defaults after reset: zero gains, full-range ramp and limits
  task automatic test_reset_defaults();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_item(OP_PRESET, 16'h7fff, 16'h0000);
    send_item(OP_SAMPLE, 16'h8000, 16'hffff);
    // setpoint one fall step away: target lands on the setpoint itself
    send_item(OP_RUN, 16'h0000, 16'h8000);
    // far above: the target only moves by the rise rate
    send_item(OP_RUN, 16'hffff, 16'h7fff);
    send_item(OP_HOLD, 16'h5555, 16'haaaa);
    drain_results();
  endtask

  // raw derivative, extreme gains, narrow limits and slow ramp
  task automatic test_ramp_and_raw_derivative();
    program_config(1'b0, 16'h7fff, 16'h8000, 16'h7fff,
                   16'd1000, -16'sd1000, 16'd100, -16'sd50);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_item(OP_SAMPLE, 16'd1234, 16'h0000);
    send_item(OP_SAMPLE, -16'sd4321, 16'h0000);
    send_item(OP_RUN, 16'h0000, 16'h7fff);
    send_item(OP_RUN, 16'h0000, 16'h8000);
    send_item(OP_RUN, 16'h0000, 16'd10);
    send_item(OP_PRESET, -16'sd7, 16'h0000);
    send_item(OP_RUN, 16'h0000, 16'd20);
    drain_results();
  endtask

  // filtered derivative with a preset between samples, crossed limits and a
  // positive fall rate that must not pull the target down
  task automatic test_crossed_limits_and_preset();
    program_config(1'b1, 16'h8000, 16'h7fff, 16'h8000,
                   -16'sd100, 16'd100, 16'd500, 16'd256);
    send_item(OP_SAMPLE, 16'd500, 16'h0000);
    send_item(OP_PRESET, 16'd300, 16'h0000);
    send_item(OP_RUN, 16'h0000, 16'h8000);
    send_item(OP_RUN, 16'h0000, 16'd5);
    send_item(OP_SAMPLE, 16'h7fff, 16'h0000);
    send_item(OP_RUN, 16'h0000, 16'h7fff);
    send_item(OP_HOLD, 16'hffff, 16'hffff);
    drain_results();
  endtask

  // result side holds off while beats keep coming: the queue fills and the
  // item channel must stall without losing or reordering anything
  task automatic test_backpressure();
    int sent;
    program_config(1'b1, 16'd256, 16'd32, 16'd128,
                   16'h7fff, 16'h8000, 16'd400, -16'sd400);
    src_idle_en    = 1'b0;
    sink_idle_en   = 1'b0;
    ready_hold_req = 40;
    sent = 0;
    while (sent < 24) send_control_cycle(sent);
    drain_results();
  endtask

  // random control cycles under a fresh register setting per phase; the
  // first phases run with no idling on either side
  task automatic test_random_phases();
    int sent;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0)
        program_config(1'b0, 16'h7fff, 16'h8000, 16'h7fff,
                       16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      else
        program_random_config();
      src_idle_en  = (ph >= 2);
      sink_idle_en = (ph >= 2);
      sent = 0;
      while (sent < 62) send_control_cycle(sent);
      // pause the sender until everything is back before the next setting
      drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    item_bus.valid    = 1'b0;
    item_bus.opcode   = OP_SAMPLE;
    item_bus.feedback = '0;
    item_bus.setpoint = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_DERIV_MODE;
    cfg_bus.data      = '0;
    result_bus.ready  = 1'b0;
    mismatch_count    = 0;
    beats_checked     = 0;
    cycle_count       = 0;
    src_idle_en       = 1'b0;
    sink_idle_en      = 1'b0;
    ready_hold_req    = 0;
    ready_hold_left   = 0;
    plant_level       = 0;
    reset_controller();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_ramp_and_raw_derivative();
    test_crossed_limits_and_preset();
    test_backpressure();
    test_random_phases();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outputs_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pwr_pkg.sv
hw/rtl/pwr_item_if.sv
hw/rtl/pwr_result_if.sv
hw/rtl/pwr_cfg_if.sv
hw/rtl/pwr_front.sv
hw/rtl/pwr_back.sv
hw/rtl/pid_with_ramp_and_average_filter_core.sv
verif/tb_top.sv
